// ===== rtl/core/ecfan_pkg.sv =====
package ecfan_pkg;

	localparam logic [1:0] FUNC_PORT_WR = 2'd0;
	localparam logic [1:0] FUNC_PORT_RD = 2'd1;
	localparam logic [1:0] FUNC_SENSOR  = 2'd2;

	localparam logic [7:0] CMD_READ   = 8'h80;
	localparam logic [7:0] CMD_WRITE  = 8'h81;
	localparam logic [7:0] REG_MODE   = 8'h23;
	localparam logic [7:0] REG_DUTY   = 8'h2D;
	localparam logic [7:0] REG_RPM_HI = 8'h2E;
	localparam logic [7:0] REG_RPM_LO = 8'h2F;
	localparam logic [7:0] REG_TEMP   = 8'h70;
	localparam logic [7:0] MODE_RESET = 8'h02;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_RD_ADDR  = 4'b0010,
		PH_WR_ADDR  = 4'b0100,
		PH_WR_VALUE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic        sensor_en;
		logic [7:0]  addr;
		logic [7:0]  wdata;
		logic [15:0] rpm;
		logic [7:0]  temp;
	} space_req_t;

	typedef struct packed {
		logic [7:0] rd_data;
		logic [7:0] mode;
		logic [7:0] duty;
	} space_rsp_t;

endpackage

// ===== rtl/core/ec_host_interface_fan_regs.sv =====
// A beat accepted goes into the stage-1 register, then into the output register.
// Throughput: one beat per cycle while out_ready drains results; the register
// RAM has one read and one write port, and the output register lets a new beat
// in while a result waits. Reset clears the transaction state, OBF, the output
// buffer and the entry valid bits; the RAM itself is not cleared.
module ec_host_interface_fan_regs #(
	parameter int SPACE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        to_command_port,
	input  logic [7:0]  write_byte,
	input  logic [15:0] rpm_sample,
	input  logic [7:0]  temp_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic [7:0]  cur_mode,
	output logic [7:0]  cur_duty,
	output logic        bad_command
);
	import ecfan_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic       out_full_q, out_full_d;
	logic [7:0] out_buffer_q;

	logic       s1_valid_q;
	logic       load_s1;
	logic       use_buf_s1;
	logic [7:0] rd_fixed_s1;
	logic [7:0] mode_s1;
	logic [7:0] duty_s1;
	logic       bad_s1;

	logic       out_valid_q;

	space_req_t req;
	space_rsp_t rsp;

	logic       accept;
	logic       s1_move;
	logic       load_d;
	logic       use_buf_d;
	logic [7:0] rd_fixed_d;
	logic       bad_d;

	assign s1_move  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_move;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d       = phase_q;
		pending_d     = pending_q;
		out_full_d    = out_full_q;
		load_d        = 1'b0;
		use_buf_d     = 1'b0;
		rd_fixed_d    = 8'h00;
		bad_d         = 1'b0;
		req.rd_en     = 1'b0;
		req.wr_en     = 1'b0;
		req.sensor_en = 1'b0;
		req.addr      = write_byte;
		req.wdata     = write_byte;
		req.rpm       = rpm_sample;
		req.temp      = temp_sample;
		if (accept) begin
			unique case (func)
				FUNC_PORT_WR: begin
					if (to_command_port) begin
						if (write_byte == CMD_READ) begin
							phase_d = PH_RD_ADDR;
						end else if (write_byte == CMD_WRITE) begin
							phase_d = PH_WR_ADDR;
						end else begin
							bad_d   = 1'b1;
							phase_d = PH_IDLE;
						end
					end else begin
						unique case (phase_q)
							PH_RD_ADDR: begin
								req.rd_en  = 1'b1;
								load_d     = 1'b1;
								out_full_d = 1'b1;
								phase_d    = PH_IDLE;
							end
							PH_WR_ADDR: begin
								pending_d = write_byte;
								phase_d   = PH_WR_VALUE;
							end
							PH_WR_VALUE: begin
								req.wr_en = 1'b1;
								req.addr  = pending_q;
								phase_d   = PH_IDLE;
							end
							default: begin
							end
						endcase
					end
				end
				FUNC_PORT_RD: begin
					if (to_command_port) begin
						rd_fixed_d = {7'd0, out_full_q};
					end else begin
						use_buf_d  = 1'b1;
						out_full_d = 1'b0;
					end
				end
				FUNC_SENSOR: begin
					req.sensor_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	ecfan_space #(
		.SPACE_DEPTH(SPACE_DEPTH)
	) u_space (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pending_q    <= '0;
			out_full_q   <= 1'b0;
			out_buffer_q <= '0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			out_full_q <= out_full_d;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				if (load_s1) begin
					out_buffer_q <= rsp.rd_data;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			load_s1     <= load_d;
			use_buf_s1  <= use_buf_d;
			rd_fixed_s1 <= rd_fixed_d;
			mode_s1     <= rsp.mode;
			duty_s1     <= rsp.duty;
			bad_s1      <= bad_d;
		end
		if (s1_move) begin
			read_byte   <= use_buf_s1 ? out_buffer_q : rd_fixed_s1;
			cur_mode    <= mode_s1;
			cur_duty    <= duty_s1;
			bad_command <= bad_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/ecfan_space.sv =====
module ecfan_space #(
	parameter int SPACE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ecfan_pkg::space_req_t  req,
	output ecfan_pkg::space_rsp_t  rsp
);
	import ecfan_pkg::*;

	localparam int AW = $clog2(SPACE_DEPTH);

	logic [7:0]             mem [SPACE_DEPTH];
	logic [SPACE_DEPTH-1:0] valid_q;
	logic [7:0]             mem_rd_q;
	logic                   rd_zero_q;
	logic                   rd_shadow_q;
	logic [7:0]             shadow_rd_q;
	logic [7:0]             mode_q;
	logic [7:0]             duty_q;
	logic [7:0]             rpm_hi_q;
	logic [7:0]             rpm_lo_q;
	logic [7:0]             temp_q;

	logic          in_range;
	logic [AW-1:0] idx;
	logic          is_shadow;
	logic [7:0]    shadow_val;

	assign in_range  = {1'b0, req.addr} < 9'(SPACE_DEPTH);
	assign idx       = req.addr[AW-1:0];
	assign is_shadow = (req.addr == REG_MODE) || (req.addr == REG_DUTY) ||
		(req.addr == REG_RPM_HI) || (req.addr == REG_RPM_LO) || (req.addr == REG_TEMP);

	always_comb begin
		shadow_val = temp_q;
		priority if (req.addr == REG_MODE) begin
			shadow_val = mode_q;
		end else if (req.addr == REG_DUTY) begin
			shadow_val = duty_q;
		end else if (req.addr == REG_RPM_HI) begin
			shadow_val = rpm_hi_q;
		end else if (req.addr == REG_RPM_LO) begin
			shadow_val = rpm_lo_q;
		end else begin
			shadow_val = temp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && in_range && !is_shadow) begin
			mem[idx] <= req.wdata;
		end
		if (req.rd_en) begin
			mem_rd_q    <= mem[idx];
			shadow_rd_q <= shadow_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_zero_q   <= 1'b1;
			rd_shadow_q <= 1'b0;
			mode_q      <= MODE_RESET;
			duty_q      <= '0;
			rpm_hi_q    <= '0;
			rpm_lo_q    <= '0;
			temp_q      <= '0;
		end else begin
			if (req.wr_en && in_range) begin
				if (!is_shadow) begin
					valid_q[idx] <= 1'b1;
				end
				if (req.addr == REG_MODE)   mode_q   <= req.wdata;
				if (req.addr == REG_DUTY)   duty_q   <= req.wdata;
				if (req.addr == REG_RPM_HI) rpm_hi_q <= req.wdata;
				if (req.addr == REG_RPM_LO) rpm_lo_q <= req.wdata;
				if (req.addr == REG_TEMP)   temp_q   <= req.wdata;
			end
			if (req.sensor_en) begin
				rpm_hi_q <= req.rpm[15:8];
				rpm_lo_q <= req.rpm[7:0];
				temp_q   <= req.temp;
			end
			if (req.rd_en) begin
				rd_shadow_q <= in_range && is_shadow;
				rd_zero_q   <= !in_range || (!is_shadow && !valid_q[idx]);
			end
		end
	end

	assign rsp.rd_data = rd_zero_q ? 8'h00 : (rd_shadow_q ? shadow_rd_q : mem_rd_q);
	assign rsp.mode    = (req.wr_en && req.addr == REG_MODE) ? req.wdata : mode_q;
	assign rsp.duty    = (req.wr_en && req.addr == REG_DUTY) ? req.wdata : duty_q;

endmodule

// ===== tb/ec_host_interface_fan_regs_check.sv =====
`timescale 1ns / 100ps

module ec_host_interface_fan_regs_check #(
	parameter int SPACE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic        to_command_port,
	input  logic [7:0]  write_byte,
	input  logic [15:0] rpm_sample,
	input  logic [7:0]  temp_sample,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_byte,
	input  logic [7:0]  cur_mode,
	input  logic [7:0]  cur_duty,
	input  logic        bad_command,
	output int          fail_count,
	output int          pending
);

	import ecfan_pkg::*;

	typedef struct packed {
		logic [1:0]  func;
		logic        cmd_port;
		logic [7:0]  wb;
		logic [15:0] rpm;
		logic [7:0]  temp;
	} host_beat_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [7:0] mode;
		logic [7:0] duty;
		logic       bad;
	} ec_reply_t;

	phase_t     phase;
	logic [7:0] wr_addr;
	logic [7:0] obuf;
	logic       obf;
	logic [7:0] regs [256];
	ec_reply_t  due_replies [$];
	ec_reply_t  want;
	ec_reply_t  got;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [7:0] reg_get(input logic [7:0] a);
		return (a < SPACE_DEPTH) ? regs[a] : 8'h00;
	endfunction

	function automatic void reg_put(input logic [7:0] a, input logic [7:0] v);
		if (a < SPACE_DEPTH)
			regs[a] = v;
	endfunction

	function automatic ec_reply_t ec_respond(input host_beat_t b);
		ec_reply_t r;
		r = '0;
		case (b.func)
			FUNC_PORT_WR: begin
				if (b.cmd_port) begin
					if (b.wb == CMD_READ)
						phase = PH_RD_ADDR;
					else if (b.wb == CMD_WRITE)
						phase = PH_WR_ADDR;
					else begin
						r.bad = 1'b1;
						phase = PH_IDLE;
					end
				end else begin
					case (phase)
						PH_RD_ADDR: begin
							obuf = reg_get(b.wb);
							obf = 1'b1;
							phase = PH_IDLE;
						end
						PH_WR_ADDR: begin
							wr_addr = b.wb;
							phase = PH_WR_VALUE;
						end
						PH_WR_VALUE: begin
							reg_put(wr_addr, b.wb);
							phase = PH_IDLE;
						end
						default: ;
					endcase
				end
			end
			FUNC_PORT_RD: begin
				if (b.cmd_port)
					r.read_byte = {7'd0, obf};
				else begin
					r.read_byte = obuf;
					obf = 1'b0;
				end
			end
			FUNC_SENSOR: begin
				reg_put(REG_RPM_HI, b.rpm[15:8]);
				reg_put(REG_RPM_LO, b.rpm[7:0]);
				reg_put(REG_TEMP, b.temp);
			end
			default: ;
		endcase
		r.mode = reg_get(REG_MODE);
		r.duty = reg_get(REG_DUTY);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			wr_addr = 8'h00;
			obuf = 8'h00;
			obf = 1'b0;
			for (int i = 0; i < 256; i++)
				regs[i] = 8'h00;
			reg_put(REG_MODE, MODE_RESET);
			due_replies.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = '{read_byte, cur_mode, cur_duty, bad_command};
				if (due_replies.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: stray beat rd=%0h mode=%0h duty=%0h bad=%0b",
							$time, read_byte, cur_mode, cur_duty, bad_command);
					fail_count++;
				end else begin
					want = due_replies.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"%0t: mismatch rd %0h/%0h mode %0h/%0h",
								" duty %0h/%0h bad %0b/%0b (exp/act)"},
								$time, want.read_byte, got.read_byte, want.mode, got.mode,
								want.duty, got.duty, want.bad, got.bad);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				due_replies.push_back(ec_respond('{func, to_command_port, write_byte,
					rpm_sample, temp_sample}));
		end
		pending = due_replies.size();
	end

endmodule

// ===== tb/ec_host_interface_fan_regs_test.sv =====
`timescale 1ns / 100ps

module ec_host_interface_fan_regs_test;

	import ecfan_pkg::*;

	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int         LIMIT    = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic        to_command_port;
	logic [7:0]  write_byte;
	logic [15:0] rpm_sample;
	logic [7:0]  temp_sample;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_byte;
	logic [7:0]  cur_mode;
	logic [7:0]  cur_duty;
	logic        bad_command;

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int beats_sent = 0;
	int cycles = 0;
	bit squeeze = 1'b0;
	bit rx_hold = 1'b0;

	ec_host_interface_fan_regs u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.to_command_port(to_command_port),
		.write_byte(write_byte),
		.rpm_sample(rpm_sample),
		.temp_sample(temp_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.cur_mode(cur_mode),
		.cur_duty(cur_duty),
		.bad_command(bad_command)
	);

	ec_host_interface_fan_regs_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.to_command_port(to_command_port),
		.write_byte(write_byte),
		.rpm_sample(rpm_sample),
		.temp_sample(temp_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.cur_mode(cur_mode),
		.cur_duty(cur_duty),
		.bad_command(bad_command),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[ec_host_interface_fan_regs] ERROR");
			$finish;
		end
	end

	initial out_ready = 1'b0;

	always @(negedge clk)
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	// hold the result side off long enough for the block to back up
	initial begin
		wait (squeeze);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(negedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_beat(input logic [1:0] f, input logic c, input logic [7:0] b,
		input logic [15:0] rpm, input logic [7:0] tmp);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		to_command_port <= c;
		write_byte <= b;
		rpm_sample <= rpm;
		temp_sample <= tmp;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic port_write(input logic c, input logic [7:0] b);
		send_beat(FUNC_PORT_WR, c, b, 16'($urandom), 8'($urandom));
	endtask

	task automatic port_read(input logic c);
		send_beat(FUNC_PORT_RD, c, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic sensor_update(input logic [15:0] rpm, input logic [7:0] tmp);
		send_beat(FUNC_SENSOR, 1'($urandom), 8'($urandom), rpm, tmp);
	endtask

	function automatic logic [7:0] pick_addr();
		case ($urandom_range(9))
			0: return REG_MODE;
			1: return REG_DUTY;
			2: return REG_RPM_HI;
			3: return REG_RPM_LO;
			4: return REG_TEMP;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_value();
		if ($urandom_range(9) < 3)
			return 8'($urandom_range(3));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(7))
			0: return CMD_READ;
			1: return CMD_WRITE;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_transaction();
		int kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			port_write(1'b1, CMD_WRITE);
			port_write(1'b0, pick_addr());
			port_write(1'b0, pick_value());
		end else if (kind < 65) begin
			port_write(1'b1, CMD_READ);
			port_write(1'b0, pick_addr());
			if ($urandom_range(1))
				port_read(1'b1);
			if ($urandom_range(3) != 0)
				port_read(1'b0);
		end else if (kind < 75)
			sensor_update(16'($urandom), 8'($urandom));
		else if (kind < 85)
			port_read(1'($urandom_range(1)));
		else
			send_beat(2'($urandom_range(3)), 1'($urandom_range(1)), noise_byte(),
				16'($urandom), 8'($urandom));
	endtask

	task automatic random_run(input int beats);
		int start;
		start = beats_sent;
		while (beats_sent - start < beats)
			random_transaction();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_PORT_WR;
		to_command_port = 1'b0;
		write_byte = 8'h00;
		rpm_sample = 16'h0000;
		temp_sample = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 17;
		rx_idle_pct = 55;
		port_read(1'b1);
		port_read(1'b0);
		port_write(1'b0, 8'hFF);
		port_write(1'b1, CMD_READ);
		port_write(1'b0, REG_MODE);
		port_read(1'b1);
		port_read(1'b0);
		port_read(1'b1);
		port_write(1'b1, CMD_WRITE);
		port_write(1'b0, REG_DUTY);
		port_write(1'b0, 8'hFF);
		port_write(1'b1, CMD_WRITE);
		port_write(1'b1, CMD_READ);
		port_write(1'b0, 8'hFF);
		port_write(1'b1, 8'h00);
		port_write(1'b1, 8'hFF);
		port_read(1'b0);
		sensor_update(16'hFFFF, 8'hFF);
		port_write(1'b1, CMD_READ);
		port_write(1'b0, REG_RPM_HI);
		port_read(1'b0);
		send_beat(FUNC_NOP, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
		port_write(1'b1, CMD_WRITE);
		port_write(1'b0, REG_MODE);
		port_write(1'b0, 8'h00);
		sensor_update(16'h0000, 8'h00);

		random_run(630);
		tx_idle_pct = 55;
		rx_idle_pct = 17;
		random_run(630);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		squeeze = 1'b1;
		random_run(640);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[ec_host_interface_fan_regs] OK");
		else
			$display("[ec_host_interface_fan_regs] ERROR");
		$finish;
	end

endmodule
